// ----- sv/ol_pkg.sv -----
// Package for the ordered list block: sizes, operation and status codes,
// and the per-cell control word. No dependencies.
package ol_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_DELETE    = 2'd2,
    OP_SHOW      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // What a cell loads at the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_LOAD_ITEM  = 3'd1,
    CELL_TAKE_LEFT  = 3'd2,
    CELL_TAKE_RIGHT = 3'd3,
    CELL_TAKE_HEAD  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      occupied;
  } cell_ctl_t;

endpackage

// ----- sv/ol_in_if.sv -----
// Request channel of the ordered list: valid/ready plus one request word.
// Depends on ol_pkg for widths.
interface ol_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic signed [ol_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

// ----- sv/ol_out_if.sv -----
// Result channel of the ordered list: valid/ready plus one result word.
// Depends on ol_pkg for widths.
interface ol_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [ol_pkg::VAL_W-1:0]    entry_value;
  logic [4:0]                         entry_count;
  logic                               last_of_run;

  modport source (output valid, output status, output entry_value,
                  output entry_count, output last_of_run, input ready);
  modport sink   (input valid, input status, input entry_value,
                  input entry_count, input last_of_run, output ready);
endinterface

// ----- sv/ol_cell.sv -----
// One list position: holds an entry, compares it with the search value and
// loads from itself, a neighbour, the head or the new item. Uses ol_pkg.
module ol_cell (
  input  logic                            clk,
  input  ol_pkg::cell_ctl_t               ctl,
  input  logic signed [ol_pkg::VAL_W-1:0] item_value,
  input  logic signed [ol_pkg::VAL_W-1:0] left_value,
  input  logic signed [ol_pkg::VAL_W-1:0] right_value,
  input  logic signed [ol_pkg::VAL_W-1:0] head_value,
  output logic signed [ol_pkg::VAL_W-1:0] value,
  output logic                            match
);

  logic signed [ol_pkg::VAL_W-1:0] value_next;

  always_comb begin
    unique case (ctl.cmd)
      ol_pkg::CELL_LOAD_ITEM:  value_next = item_value;
      ol_pkg::CELL_TAKE_LEFT:  value_next = left_value;
      ol_pkg::CELL_TAKE_RIGHT: value_next = right_value;
      ol_pkg::CELL_TAKE_HEAD:  value_next = head_value;
      default:                 value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Only a held entry may match.
  assign match = ctl.occupied && (value == item_value);

endmodule

// ----- sv/ordered_list_with_delete_by_value.sv -----
// Top level of the ordered list: a chain of ol_cell positions, head at cell 0,
// the entry count, the display sequencer and the result register.
// Uses ol_pkg, ol_in_if, ol_out_if and ol_cell.
//
//   channel   dir  word fields                                   
//   in_item   in   opcode, item_value                            
//   out_item  out  status, entry_value, entry_count, last_of_run 
//
// Insert and delete act on all cells in parallel: every cell compares and shifts at once.
// Display of an empty list gives one empty status word; otherwise the request
// starts the sequencer and each held entry goes out in turn: while the result
// is free the chain rotates occupied cells one place a cycle; the head goes out.
// A stalled result holds the chain and the sequencer; no new word is taken
// until the result register is free and any display has finished.
// Reset clears the count, the sequencer and the result valid; cells are not reset.
module ordered_list_with_delete_by_value (
  input  logic        clk,
  input  logic        rst,
  ol_in_if.sink       in_item,
  ol_out_if.source    out_item
);

  localparam int DEPTH = ol_pkg::DEPTH;
  localparam int CNT_W = ol_pkg::CNT_W;
  localparam int IDX_W = ol_pkg::IDX_W;
  localparam int VAL_W = ol_pkg::VAL_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SHOW = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic [IDX_W-1:0]   show_idx, show_idx_next;

  logic               out_valid, out_valid_next;
  ol_pkg::status_t    out_status, out_status_next;
  logic signed [VAL_W-1:0] out_value, out_value_next;
  logic [CNT_W-1:0]   out_count, out_count_next;
  logic               out_last, out_last_next;

  ol_pkg::cell_ctl_t       cell_ctl [DEPTH];
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        cell_match;
  logic [DEPTH-1:0]        hit_upto;

  logic               out_free, accept, full, found, show_step, show_last;
  logic [CNT_W-1:0]   last_pos;
  ol_pkg::opcode_t    op;

  assign op        = ol_pkg::opcode_t'(in_item.opcode);
  assign out_free  = !out_valid || out_item.ready;
  assign in_item.ready = (state == S_IDLE) && out_free;
  assign accept    = in_item.valid && in_item.ready;
  assign full      = (held_count == CNT_W'(DEPTH));
  assign last_pos  = held_count - CNT_W'(1);
  assign show_step = (state == S_SHOW) && out_free;
  assign show_last = (CNT_W'(show_idx) == last_pos);

  // Mark every cell at or behind the first match.
  always_comb begin
    hit_upto[0] = cell_match[0];
    for (int i = 1; i < DEPTH; i++) begin
      hit_upto[i] = hit_upto[i-1] || cell_match[i];
    end
  end
  assign found = hit_upto[DEPTH-1];

  // Per-cell commands.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].occupied = (CNT_W'(i) < held_count);
      cell_ctl[i].cmd      = ol_pkg::CELL_HOLD;
      if (accept && !full && op == ol_pkg::OP_INS_FRONT) begin
        cell_ctl[i].cmd = (i == 0) ? ol_pkg::CELL_LOAD_ITEM : ol_pkg::CELL_TAKE_LEFT;
      end else if (accept && !full && op == ol_pkg::OP_INS_BACK) begin
        if (CNT_W'(i) == held_count) cell_ctl[i].cmd = ol_pkg::CELL_LOAD_ITEM;
      end else if (accept && op == ol_pkg::OP_DELETE) begin
        if (hit_upto[i]) cell_ctl[i].cmd = ol_pkg::CELL_TAKE_RIGHT;
      end else if (show_step) begin
        // Rotate the occupied cells: the tail position takes the head.
        if (CNT_W'(i) == last_pos)     cell_ctl[i].cmd = ol_pkg::CELL_TAKE_HEAD;
        else if (CNT_W'(i) < last_pos) cell_ctl[i].cmd = ol_pkg::CELL_TAKE_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ol_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[g]),
      .item_value  (in_item.item_value),
      .left_value  ((g == 0) ? in_item.item_value : cell_val[(g == 0) ? 0 : g-1]),
      .right_value ((g == DEPTH-1) ? cell_val[0] : cell_val[(g == DEPTH-1) ? g : g+1]),
      .head_value  (cell_val[0]),
      .value       (cell_val[g]),
      .match       (cell_match[g])
    );
  end

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    show_idx_next   = show_idx;
    out_valid_next  = out_valid && !out_item.ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_count_next  = out_count;
    out_last_next   = out_last;

    if (accept) begin
      out_value_next = '0;
      out_last_next  = 1'b1;
      unique case (op)
        ol_pkg::OP_INS_FRONT, ol_pkg::OP_INS_BACK: begin
          out_valid_next = 1'b1;
          if (full) begin
            out_status_next = ol_pkg::ST_FULL;
          end else begin
            out_status_next = ol_pkg::ST_OK;
            held_count_next = held_count + CNT_W'(1);
          end
        end
        ol_pkg::OP_DELETE: begin
          out_valid_next = 1'b1;
          if (found) begin
            out_status_next = ol_pkg::ST_OK;
            held_count_next = held_count - CNT_W'(1);
          end else begin
            out_status_next = ol_pkg::ST_NOT_FOUND;
          end
        end
        ol_pkg::OP_SHOW: begin
          if (held_count == '0) begin
            out_valid_next  = 1'b1;
            out_status_next = ol_pkg::ST_EMPTY;
          end else begin
            state_next    = S_SHOW;
            show_idx_next = '0;
          end
        end
      endcase
      out_count_next = held_count_next;
    end else if (show_step) begin
      out_valid_next  = 1'b1;
      out_status_next = ol_pkg::ST_OK;
      out_value_next  = cell_val[0];
      out_count_next  = held_count;
      out_last_next   = show_last;
      show_idx_next   = show_idx + IDX_W'(1);
      if (show_last) state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      show_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      show_idx   <= show_idx_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

  assign out_item.valid       = out_valid;
  assign out_item.status      = out_status;
  assign out_item.entry_value = out_value;
  assign out_item.entry_count = out_count;
  assign out_item.last_of_run = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_show_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> (CNT_W'(show_idx) < held_count))
    else $error("display index past the tail");

  a_front_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && op == ol_pkg::OP_INS_FRONT && !full)
      |=> (cell_val[0] == $past(in_item.item_value)))
    else $error("front insert did not reach the head");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ol_pkg::ST_EMPTY) |-> (out_count == '0 && out_last))
    else $error("empty status with entries");

  a_show_no_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> !in_item.ready)
    else $error("word taken during display");

endmodule
